FILE: rtl/first_fit_free_list_allocator_defines.svh
// Assertion macros shared by the allocator checker
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
// Implication check, disabled while reset is asserted
`define FFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check, disabled while reset is asserted
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator
`default_nettype none
package ffa_pkg;
    localparam int NumEntries = 1024;
    localparam int IdxW = $clog2(NumEntries);
    localparam int CntW = IdxW + 1;
    localparam logic [31:0] PageAdd  = 32'h0000_0fff;
    localparam logic [31:0] PageMask = 32'hffff_f000;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StNoFit   = 2'd1;
    localparam logic [1:0] StDropped = 2'd2;

    typedef enum logic [3:0] {
        t_idle_s, t_arel_s, t_acmp_s, t_fcmp_s, t_fdec_s, t_fprv_s, t_fwb_s,
        t_shl_rd_s, t_shl_wr_s, t_shr_rd_s, t_shr_wr_s, t_done_s
    } t_state;

    typedef struct packed {
        logic        we;
        logic [IdxW-1:0] waddr;
        logic [31:0] wstart;
        logic [31:0] wlen;
        logic [IdxW-1:0] raddr;
    } t_mem_req;
endpackage
`default_nettype wire

FILE: rtl/first_fit_free_list_allocator.sv
// First-fit free-list allocator top level
// Each word takes an entry-by-entry scan of the table of N entries and, where
// entries move, an entry-by-entry shift through the table RAM's single read port.
// One word at a time: s_axis_tready is low from acceptance until the result
// is taken. Reset (synchronous, low) empties the table and clears counters.
`default_nettype none
module first_fit_free_list_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // addr, size, page_round, pad
    input  wire logic        s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [151:0] m_axis_tdata // result_addr, status, free_bytes_total,
                                      // entries_in_use, peak_entries,
                                      // lost_count, lost_bytes
);
    import ffa_pkg::*;
    t_mem_req w_req;
    logic [31:0] w_rs, w_rl, r_addr, r_size, w_sz, w_ra, w_fs, w_lc, w_lb;
    logic r_op, r_busy, r_ov, w_start, w_done;
    logic [1:0] w_st;
    logic [CntW-1:0] w_cnt, w_pk;
    logic [151:0] r_out;

    assign w_start = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = !r_busy;
    assign w_sz = s_axis_tdata[64] ? ((s_axis_tdata[63:32] + PageAdd) & PageMask)
                                   : s_axis_tdata[63:32];

    // hold request, track output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (w_start) r_busy <= 1'b1;
            else if (r_ov && m_axis_tready) r_busy <= 1'b0;
            if (w_done) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
        if (w_start) begin
            r_op <= s_axis_tuser; r_addr <= s_axis_tdata[31:0]; r_size <= w_sz;
        end
        if (w_done) r_out <= {w_lb, w_lc, w_pk, w_cnt, w_fs, w_st, w_ra};
    end

    ffa_table u_table (.i_clk, .i_req(w_req), .o_start(w_rs), .o_len(w_rl));
    ffa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(w_start),
        .i_op(w_start ? s_axis_tuser : r_op),
        .i_addr(w_start ? s_axis_tdata[31:0] : r_addr),
        .i_size(w_start ? w_sz : r_size),
        .i_rd_start(w_rs), .i_rd_len(w_rl), .o_req(w_req),
        .o_done(w_done), .o_result_addr(w_ra), .o_status(w_st),
        .o_free_sum(w_fs), .o_count(w_cnt), .o_peak(w_pk),
        .o_lost_count(w_lc), .o_lost_bytes(w_lb)
    );
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;
endmodule
`default_nettype wire

FILE: rtl/ffa_table.sv
// Region table memory: one write port and one registered read port
`default_nettype none
module ffa_table (
    input  wire logic              i_clk,
    input  wire ffa_pkg::t_mem_req i_req,
    output logic [31:0]            o_start,
    output logic [31:0]            o_len
);
    import ffa_pkg::*;
    logic [63:0] r_mem [NumEntries];
    logic [63:0] r_rd;

    // write and read the table
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= {i_req.wstart, i_req.wlen};
        end
        r_rd <= r_mem[i_req.raddr];
    end
    assign o_start = r_rd[63:32];
    assign o_len   = r_rd[31:0];
endmodule
`default_nettype wire

FILE: rtl/ffa_ctrl.sv
// Sequencer: scans, updates and shifts the region table, one entry a step
`default_nettype none
module ffa_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_op,
    input  wire logic [31:0]        i_addr,
    input  wire logic [31:0]        i_size,
    input  wire logic [31:0]        i_rd_start,
    input  wire logic [31:0]        i_rd_len,
    output ffa_pkg::t_mem_req       o_req,
    output logic                    o_done,
    output logic [31:0]             o_result_addr,
    output logic [1:0]              o_status,
    output logic [31:0]             o_free_sum,
    output logic [ffa_pkg::CntW-1:0] o_count,
    output logic [ffa_pkg::CntW-1:0] o_peak,
    output logic [31:0]             o_lost_count,
    output logic [31:0]             o_lost_bytes
);
    import ffa_pkg::*;

    t_state r_state, n_state;
    logic [CntW-1:0] r_k, n_k;        // scan index
    logic [CntW-1:0] r_j, n_j;        // shift index
    logic [CntW-1:0] r_cnt, n_cnt, r_peak, n_peak;
    logic [31:0] r_sum, n_sum, r_lc, n_lc, r_lb, n_lb;
    logic [31:0] r_where, n_where;
    logic [1:0]  r_st, n_st;
    logic [31:0] r_ps, n_ps, r_pl, n_pl; // previous entry / working entry
    logic [31:0] r_ns, n_ns, r_nl, n_nl; // next entry
    logic        r_nv, n_nv;             // next entry exists
    logic [31:0] r_hs, n_hs, r_hl, n_hl; // shift holding word
    logic [31:0] w_sum_a;                // shared adder output
    logic [31:0] w_add_a, w_add_b;

    // shared 32-bit adder
    assign w_sum_a = w_add_a + w_add_b;

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle_s;
            r_cnt <= '0; r_peak <= '0; r_sum <= '0; r_lc <= '0; r_lb <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt; r_peak <= n_peak; r_sum <= n_sum;
            r_lc <= n_lc; r_lb <= n_lb;
        end
        r_k <= n_k; r_j <= n_j; r_where <= n_where; r_st <= n_st;
        r_ps <= n_ps; r_pl <= n_pl; r_ns <= n_ns; r_nl <= n_nl; r_nv <= n_nv;
        r_hs <= n_hs; r_hl <= n_hl;
    end

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_k = r_k; n_j = r_j; n_cnt = r_cnt; n_peak = r_peak; n_sum = r_sum;
        n_lc = r_lc; n_lb = r_lb; n_where = r_where; n_st = r_st;
        n_ps = r_ps; n_pl = r_pl; n_ns = r_ns; n_nl = r_nl; n_nv = r_nv;
        n_hs = r_hs; n_hl = r_hl;
        w_add_a = '0; w_add_b = '0;
        o_req = '0;
        o_req.raddr = r_k[IdxW-1:0];
        unique case (r_state)
            t_idle_s: begin
                if (i_start) begin
                    n_k = '0; n_where = '0; n_st = StOk;
                    o_req.raddr = '0;
                    if (r_cnt == '0) begin
                        n_state = i_op ? t_fdec_s : t_done_s;
                        n_st = i_op ? StOk : StNoFit;
                    end else begin
                        n_state = i_op ? t_fcmp_s : t_acmp_s;
                    end
                end
            end
            t_acmp_s: begin
                // entry r_k is on the read port
                if (i_rd_len >= i_size) begin
                    n_where = i_rd_start;
                    w_add_a = i_rd_start; w_add_b = i_size;
                    n_ps = w_sum_a;
                    n_pl = i_rd_len - i_size;
                    n_state = t_arel_s;
                end else if (r_k + 1'b1 == r_cnt) begin
                    n_st = StNoFit; n_state = t_done_s;
                end else begin
                    n_k = r_k + 1'b1;
                    o_req.raddr = n_k[IdxW-1:0];
                end
            end
            t_arel_s: begin
                w_add_a = r_sum; w_add_b = ~i_size + 32'd1;
                n_sum = w_sum_a;
                if (r_pl == '0) begin
                    n_cnt = r_cnt - 1'b1;
                    n_j = r_k;
                    o_req.raddr = n_j[IdxW-1:0] + 1'b1;
                    n_state = (r_k + 1'b1 < r_cnt) ? t_shl_rd_s : t_done_s;
                end else begin
                    o_req.we = 1'b1; o_req.waddr = r_k[IdxW-1:0];
                    o_req.wstart = r_ps; o_req.wlen = r_pl;
                    n_state = t_done_s;
                end
            end
            t_shl_rd_s: begin
                // entry j+1 is on the read port; copy it down
                o_req.we = 1'b1; o_req.waddr = r_j[IdxW-1:0];
                o_req.wstart = i_rd_start; o_req.wlen = i_rd_len;
                n_j = r_j + 1'b1;
                o_req.raddr = n_j[IdxW-1:0] + 1'b1;
                n_state = (n_j < r_cnt) ? t_shl_wr_s : t_done_s;
            end
            t_shl_wr_s: begin
                o_req.raddr = r_j[IdxW-1:0] + 1'b1;
                n_state = t_shl_rd_s;
            end
            t_fcmp_s: begin
                // find first entry with start > addr
                if (i_rd_start > i_addr) begin
                    n_ns = i_rd_start; n_nl = i_rd_len; n_nv = 1'b1;
                    n_state = t_fdec_s;
                    o_req.raddr = r_k[IdxW-1:0] - 1'b1;
                end else if (r_k + 1'b1 == r_cnt) begin
                    n_k = r_cnt; n_nv = 1'b0;
                    n_state = t_fdec_s;
                    o_req.raddr = r_k[IdxW-1:0];
                end else begin
                    n_k = r_k + 1'b1;
                    o_req.raddr = n_k[IdxW-1:0];
                end
                if (r_cnt == '0) n_nv = 1'b0;
            end
            t_fdec_s: begin
                // wait for previous entry read
                if (r_cnt == '0) n_nv = 1'b0;
                n_state = t_fprv_s;
                o_req.raddr = r_k[IdxW-1:0] - 1'b1;
            end
            t_fprv_s: begin
                n_ps = i_rd_start; n_pl = i_rd_len;
                w_add_a = i_rd_start; w_add_b = i_rd_len;
                if (r_k != '0 && w_sum_a == i_addr) begin
                    n_pl = i_rd_len + i_size;
                    n_state = t_fwb_s;
                    n_st = StOk;
                    n_sum = r_sum + i_size;
                end else if (r_nv && (i_addr + i_size == r_ns)) begin
                    o_req.we = 1'b1; o_req.waddr = r_k[IdxW-1:0];
                    o_req.wstart = i_addr; o_req.wlen = r_nl + i_size;
                    n_sum = r_sum + i_size;
                    n_state = t_done_s;
                end else if (r_cnt < CntW'(NumEntries)) begin
                    n_sum = r_sum + i_size;
                    n_cnt = r_cnt + 1'b1;
                    if (r_peak < n_cnt) n_peak = n_cnt;
                    n_hs = i_addr; n_hl = i_size;
                    n_j = r_k;
                    o_req.raddr = r_k[IdxW-1:0];
                    n_state = t_shr_wr_s;
                end else begin
                    n_lc = r_lc + 32'd1; n_lb = r_lb + i_size;
                    n_st = StDropped; n_state = t_done_s;
                end
            end
            t_fwb_s: begin
                // merge with previous, maybe with next too
                w_add_a = r_pl; w_add_b = r_nl;
                o_req.we = 1'b1; o_req.waddr = r_k[IdxW-1:0] - 1'b1;
                o_req.wstart = r_ps;
                if (r_nv && (i_addr + i_size == r_ns)) begin
                    o_req.wlen = w_sum_a;
                    n_cnt = r_cnt - 1'b1;
                    n_j = r_k;
                    o_req.raddr = r_k[IdxW-1:0] + 1'b1;
                    n_state = (r_k + 1'b1 < r_cnt) ? t_shl_rd_s : t_done_s;
                end else begin
                    o_req.wlen = r_pl;
                    n_state = t_done_s;
                end
            end
            t_shr_wr_s: begin
                // insert held word at j, pick up old entry j from the read port
                n_hs = i_rd_start; n_hl = i_rd_len;
                o_req.raddr = r_j[IdxW-1:0] + 1'b1;
                o_req.we = 1'b1; o_req.waddr = r_j[IdxW-1:0];
                o_req.wstart = r_hs; o_req.wlen = r_hl;
                n_state = t_shr_rd_s;
            end
            t_shr_rd_s: begin
                // advance to the next slot and read its old entry
                n_j = r_j + 1'b1;
                o_req.raddr = n_j[IdxW-1:0];
                n_state = (n_j < r_cnt) ? t_shr_wr_s : t_done_s;
            end
            t_done_s: begin
                n_state = t_idle_s;
            end
            default: n_state = t_idle_s;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_state == t_done_s);
    end
    assign o_result_addr = r_where;
    assign o_status      = r_st;
    assign o_free_sum    = r_sum;
    assign o_count       = r_cnt;
    assign o_peak        = r_peak;
    assign o_lost_count  = r_lc;
    assign o_lost_bytes  = r_lb;
endmodule
`default_nettype wire

FILE: rtl/ffa_checker.sv
// Port-level checker for the allocator, bound to the top level
`default_nettype none
`include "first_fit_free_list_allocator_defines.svh"
module ffa_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [151:0] m_axis_tdata
);
    `FFA_ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "accepted while result pending")
    `FFA_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
    `FFA_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[33:32] != 2'd3, "bad status")
    `FFA_ASSERT_IMPL(a_peak, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[87:77] >= m_axis_tdata[76:66], "peak below count")
endmodule
bind first_fit_free_list_allocator ffa_checker u_chk (.*);
`default_nettype wire
